@@ design/bdz_pkg.sv @@
// Shared types and constants for the BDZ assign and rank block.
package bdz_pkg;

  // Vertex index, packed value word and rank widths.
  localparam int VERT_W  = 12;
  localparam int WADDR_W = 10;
  localparam int WORDS   = 1024;
  localparam int RANK_W  = 13;
  localparam int MEMW_W  = 12;

  // Largest vertex count and the block size limits.
  localparam logic [12:0] MAX_COUNT  = 13'd4096;
  localparam logic [3:0]  LG_MIN     = 4'd2;
  localparam logic [3:0]  LG_MAX     = 4'd12;
  localparam logic [1:0]  UNASSIGNED = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_BLOCK_LOG2   = 1'b1;

  // Operation codes carried by an item.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ASSIGN = 2'd1,
    OP_BUILD  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  // Control sequencer states.
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_AS_RD,
    ST_AS_CAP,
    ST_AS_FIX,
    ST_AS_MRD,
    ST_AS_MWR,
    ST_BR,
    ST_RQ_BASE,
    ST_RQ,
    ST_OUT
  } state_t;

  // One vertex of an edge: its mark and its 2-bit value.
  typedef struct packed {
    logic       mark;
    logic [1:0] val;
  } vslot_t;

  // The three vertices of an edge with their current marks and values.
  typedef struct packed {
    logic [2:0][VERT_W-1:0] vert;
    vslot_t [2:0]           slot;
  } edge_t;

endpackage

@@ design/bdz_assign_and_rank_core.sv @@
// Top level of the BDZ assign and rank block: value memory, rank table and sequencer.
//
// Items arrive on in_valid/in_stall with an operation code and its operands; an
// item is taken at a clock edge with in_valid high and in_stall low. Clear and
// build produce no result, nor does assign edge. A rank query gives one result
// on out_valid/out_rank, held in an output register until out_stall is low.
// Configuration (vertex count, rank block size) is written through cfg_we,
// cfg_index and cfg_wdata; the user must write it only while the block is idle, as the block does not enforce it.
// Work per item, set by the single-port value memory walk:
//   clear: one packed word per cycle over the whole value memory.
//   assign edge: three reads, then three read-modify-writes.
//   build rank: a walk over the words in use, words = blocks in use times block size / 4.
//   rank query: a rank table read, then a walk from the block start to the queried word.
// One item is worked on at a time; in_stall is high while it runs.
// After reset the block sweeps the value memory, setting every value unassigned
// and every mark clear, and holds in_stall high meanwhile.
// A finished query waits for the output register; if the receiver stalls, the
// result stays put and the block holds the next query at its end.
module bdz_assign_and_rank_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [12:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_op,
  input  logic [bdz_pkg::VERT_W-1:0]    in_vertex_a,
  input  logic [bdz_pkg::VERT_W-1:0]    in_vertex_b,
  input  logic [bdz_pkg::VERT_W-1:0]    in_vertex_c,
  input  logic [bdz_pkg::VERT_W-1:0]    in_query_vertex,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bdz_pkg::RANK_W-1:0]    out_rank
);
  import bdz_pkg::*;

  // Registers.
  state_t              state_r, state_nxt;
  logic [10:0]         cnt_r, cnt_nxt;
  logic [10:0]         last_r, last_nxt;
  logic [1:0]          k_r, k_nxt;
  logic                pend_r, pend_nxt;
  logic [WADDR_W-1:0]  pw_r, pw_nxt;
  logic [3:0]          lg_r, lg_nxt;
  logic [VERT_W-1:0]   q_r, q_nxt;
  logic [RANK_W-1:0]   acc_r, acc_nxt;
  logic [12:0]         cfg_count_r;
  logic [3:0]          cfg_lg_r;
  edge_t               edge_r, edge_nxt, edge_calc;
  logic                out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0]   out_rank_r, out_rank_nxt;

  // Memory ports.
  logic [MEMW_W-1:0]   vmem [WORDS];
  logic [RANK_W-1:0]   cmem [WORDS];
  logic                vm_re, vm_we, cm_re, cm_we;
  logic [WADDR_W-1:0]  vm_raddr, vm_waddr, cm_raddr, cm_waddr;
  logic [MEMW_W-1:0]   vm_wdata, vm_q_r;
  logic [RANK_W-1:0]   cm_wdata, cm_q_r;

  // Derived values.
  logic                accept, out_free;
  logic [3:0]          lg_eff, lg_sh;
  logic [12:0]         n_eff;
  logic [13:0]         nsum, nb, twords;
  logic [VERT_W-1:0]   qstart;
  logic [WADDR_W-1:0]  blkmask;
  logic [2:0]          lim;

  // Mark and value of one vertex within its packed word.
  function automatic vslot_t slot_of(input logic [MEMW_W-1:0] w, input logic [1:0] s);
    vslot_t r;
    r.val  = w[2*s +: 2];
    r.mark = w[8 + s];
    return r;
  endfunction

  // Replace one vertex within its packed word.
  function automatic logic [MEMW_W-1:0] merge(input logic [MEMW_W-1:0] w, input logic [1:0] s,
                                              input vslot_t v);
    logic [MEMW_W-1:0] r;
    r = w;
    r[2*s +: 2] = v.val;
    r[8 + s]    = v.mark;
    return r;
  endfunction

  // Assigned vertices among the lanes of a word below a limit.
  function automatic logic [2:0] pop(input logic [MEMW_W-1:0] w, input logic [2:0] l);
    logic [2:0] c;
    c = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < l && w[2*i +: 2] != UNASSIGNED) c = c + 3'd1;
    end
    return c;
  endfunction

  bdz_assign_calc u_calc (
    .edge_in  (edge_r),
    .edge_out (edge_calc)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_rank  = out_rank_r;

  // Effective configuration and walk bounds.
  always_comb begin
    if (cfg_lg_r < LG_MIN)      lg_eff = LG_MIN;
    else if (cfg_lg_r > LG_MAX) lg_eff = LG_MAX;
    else                        lg_eff = cfg_lg_r;
    n_eff   = (cfg_count_r > MAX_COUNT) ? MAX_COUNT : cfg_count_r;
    nsum    = {1'b0, n_eff} + ((14'd1 << lg_eff) - 14'd1);
    nb      = nsum >> lg_eff;
    twords  = nb << (lg_eff - LG_MIN);
    qstart  = (in_query_vertex >> lg_eff) << (lg_eff - LG_MIN);
    lg_sh   = lg_r - LG_MIN;
    blkmask = (WADDR_W'(1) << lg_sh) - WADDR_W'(1);
    lim     = (state_r == ST_RQ && {1'b0, pw_r} == last_r - 11'd1) ? {1'b0, q_r[1:0]} : 3'd4;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT, ST_CLR: begin
        if (cnt_r[WADDR_W-1:0] == WADDR_W'(WORDS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(in_op))
            OP_CLEAR:  state_nxt = ST_CLR;
            OP_ASSIGN: state_nxt = ST_AS_RD;
            OP_BUILD:  state_nxt = ST_BR;
            OP_QUERY:  state_nxt = ST_RQ_BASE;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_AS_RD:  state_nxt = ST_AS_CAP;
      ST_AS_CAP: state_nxt = (k_r == 2'd2) ? ST_AS_FIX : ST_AS_RD;
      ST_AS_FIX: state_nxt = ST_AS_MRD;
      ST_AS_MRD: state_nxt = ST_AS_MWR;
      ST_AS_MWR: state_nxt = (k_r == 2'd2) ? ST_IDLE : ST_AS_MRD;
      ST_BR: begin
        if (cnt_r == last_r && !pend_r) state_nxt = ST_IDLE;
      end
      ST_RQ_BASE: state_nxt = ST_RQ;
      ST_RQ: begin
        if (cnt_r == last_r && !pend_r) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory controls and datapath register updates.
  always_comb begin
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    k_nxt         = k_r;
    pend_nxt      = 1'b0;
    pw_nxt        = pw_r;
    lg_nxt        = lg_r;
    q_nxt         = q_r;
    acc_nxt       = acc_r;
    edge_nxt      = edge_r;
    out_rank_nxt  = out_rank_r;
    out_valid_nxt = (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;
    vm_re    = 1'b0;
    vm_raddr = edge_r.vert[k_r][VERT_W-1:2];
    vm_we    = 1'b0;
    vm_waddr = cnt_r[WADDR_W-1:0];
    vm_wdata = {4'h0, 8'hff};
    cm_re    = 1'b0;
    cm_raddr = WADDR_W'(q_r >> lg_r);
    cm_we    = 1'b0;
    cm_waddr = pw_r >> lg_sh;
    cm_wdata = acc_r;
    case (state_r)
      ST_INIT, ST_CLR: begin
        // Sweep: every value unassigned, every mark clear.
        vm_we   = 1'b1;
        cnt_nxt = cnt_r + 11'd1;
      end
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = 11'd0;
          k_nxt   = 2'd0;
          acc_nxt = '0;
          lg_nxt  = lg_eff;
          q_nxt   = in_query_vertex;
          edge_nxt.vert = {in_vertex_c, in_vertex_b, in_vertex_a};
          if (op_t'(in_op) == OP_BUILD) begin
            last_nxt = twords[10:0];
          end else if (op_t'(in_op) == OP_QUERY) begin
            cnt_nxt  = qstart[10:0];
            last_nxt = {1'b0, in_query_vertex[VERT_W-1:2]} + 11'd1;
          end
        end
      end
      ST_AS_RD, ST_AS_MRD: begin
        vm_re = 1'b1;
      end
      ST_AS_CAP: begin
        edge_nxt.slot[k_r] = slot_of(vm_q_r, edge_r.vert[k_r][1:0]);
        k_nxt = (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
      end
      ST_AS_FIX: begin
        edge_nxt = edge_calc;
      end
      ST_AS_MWR: begin
        vm_we    = 1'b1;
        vm_waddr = edge_r.vert[k_r][VERT_W-1:2];
        vm_wdata = merge(vm_q_r, edge_r.vert[k_r][1:0], edge_r.slot[k_r]);
        k_nxt    = k_r + 2'd1;
      end
      ST_BR, ST_RQ: begin
        // Stream word reads; count each word in the next cycle, from the registered read.
        vm_raddr = cnt_r[WADDR_W-1:0];
        if (cnt_r != last_r) begin
          vm_re    = 1'b1;
          cnt_nxt  = cnt_r + 11'd1;
          pend_nxt = 1'b1;
          pw_nxt   = cnt_r[WADDR_W-1:0];
        end
        if (pend_r) begin
          if (state_r == ST_BR && (pw_r & blkmask) == '0) cm_we = 1'b1;
          acc_nxt = acc_r + RANK_W'(pop(vm_q_r, lim));
        end
      end
      ST_RQ_BASE: begin
        cm_re = 1'b1;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rank_nxt  = acc_r + cm_q_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_count_r <= MAX_COUNT;
      cfg_lg_r    <= 4'd7;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_VERTEX_COUNT) cfg_count_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_BLOCK_LOG2)   cfg_lg_r    <= cfg_wdata[3:0];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    k_r        <= k_nxt;
    pw_r       <= pw_nxt;
    lg_r       <= lg_nxt;
    q_r        <= q_nxt;
    acc_r      <= acc_nxt;
    edge_r     <= edge_nxt;
    out_rank_r <= out_rank_nxt;
  end

  // Packed value and mark memory.
  always_ff @(posedge clk) begin
    if (vm_we) vmem[vm_waddr] <= vm_wdata;
    if (vm_re) vm_q_r <= vmem[vm_raddr];
  end

  // Rank table memory.
  always_ff @(posedge clk) begin
    if (cm_we) cmem[cm_waddr] <= cm_wdata;
    if (cm_re) cm_q_r <= cmem[cm_raddr];
  end

`ifndef ASSERT_OFF
  // A result appears only after a query finished its walk.
  a_out_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result without a finished query");

  // The value memory is never written while idle.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !vm_we)
    else $error("value memory written while idle");

  // The rank table is written only during a build.
  a_cmem_build_only: assert property (@(posedge clk) disable iff (!rst_n)
    cm_we |-> (state_r == ST_BR))
    else $error("rank table written outside build");
`endif

endmodule

@@ design/bdz_assign_calc.sv @@
// Value and mark update for one hyperedge, with repeated vertices handled in step order.
module bdz_assign_calc (
  input  bdz_pkg::edge_t edge_in,
  output bdz_pkg::edge_t edge_out
);
  import bdz_pkg::*;

  // Reduce a small sum modulo three.
  function automatic logic [1:0] mod3(input logic [3:0] s);
    logic [1:0] r;
    case (s)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13: r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  // Set a vertex and every alias of it within the edge.
  function automatic edge_t put(input edge_t e, input logic [1:0] i, input logic [1:0] x);
    edge_t t;
    t = e;
    for (int j = 0; j < 3; j++) begin
      if (e.vert[j] == e.vert[i]) begin
        t.slot[j].val  = x;
        t.slot[j].mark = 1'b1;
      end
    end
    return t;
  endfunction

  // Sum of two slot values, widened.
  function automatic logic [3:0] vsum(input edge_t e, input logic [1:0] i, input logic [1:0] j);
    return {2'b00, e.slot[i].val} + {2'b00, e.slot[j].val};
  endfunction

  // First unmarked vertex takes the value that makes the sum equal its position.
  always_comb begin
    edge_t e;
    e = edge_in;
    if (!e.slot[0].mark) begin
      if (!e.slot[1].mark) e = put(e, 2'd1, UNASSIGNED);
      if (!e.slot[2].mark) e = put(e, 2'd2, UNASSIGNED);
      e = put(e, 2'd0, mod3(4'd6 - vsum(e, 2'd1, 2'd2)));
    end else if (!e.slot[1].mark) begin
      if (!e.slot[2].mark) e = put(e, 2'd2, UNASSIGNED);
      e = put(e, 2'd1, mod3(4'd7 - vsum(e, 2'd0, 2'd2)));
    end else begin
      e = put(e, 2'd2, mod3(4'd8 - vsum(e, 2'd0, 2'd1)));
    end
    edge_out = e;
  end

endmodule

@@ tb/tb_bdz_assign_and_rank_core.sv @@
// Self-checking testbench for the BDZ assign and rank core: directed table, then random items.
`timescale 1ns / 1ps

module tb_bdz_assign_and_rank_core;
  import bdz_pkg::*;

  localparam int NV         = 4096;
  localparam int NBLK       = 1024;
  localparam int SETTLE     = 1100;
  localparam int HOLD_LEN   = 600;
  localparam int CYCLE_CAP  = 6000000;
  localparam int RAND_ITEMS = 1520;
  localparam int SEGMENTS   = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [12:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = OP_CLEAR;
  logic [VERT_W-1:0] in_vertex_a = '0;
  logic [VERT_W-1:0] in_vertex_b = '0;
  logic [VERT_W-1:0] in_vertex_c = '0;
  logic [VERT_W-1:0] in_query_vertex = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RANK_W-1:0] out_rank;

  bdz_assign_and_rank_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .in_vertex_c(in_vertex_c), .in_query_vertex(in_query_vertex),
    .out_valid(out_valid), .out_stall(out_stall), .out_rank(out_rank)
  );

  always #6 clk = ~clk;

  // Shadow copy of the block state.
  logic [1:0]  vert_val [NV];
  logic        vert_mark [NV];
  logic [12:0] blk_count [NBLK];
  logic        blk_built [NBLK];
  logic [12:0] vcount_reg;
  logic [3:0]  lg_reg;

  logic [RANK_W-1:0] rank_queue [$];
  int errors = 0;
  int cycles = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Directed stimulus table.
  typedef struct {
    op_t op;
    int  a, b, c, q;
    bit  typed;
    int  rank;
  } row_t;
  row_t rows [$];

  function automatic int eff_lg();
    if (lg_reg < LG_MIN) return LG_MIN;
    if (lg_reg > LG_MAX) return LG_MAX;
    return lg_reg;
  endfunction

  function automatic int eff_count();
    return (vcount_reg > MAX_COUNT) ? MAX_COUNT : vcount_reg;
  endfunction

  function automatic void clear_values();
    for (int v = 0; v < NV; v++) begin
      vert_val[v] = UNASSIGNED;
      vert_mark[v] = 1'b0;
    end
  endfunction

  // Edge assignment: the first unmarked vertex closes the sum to its position.
  function automatic void assign_edge(int a, int b, int c);
    if (!vert_mark[a]) begin
      if (!vert_mark[b]) begin vert_val[b] = UNASSIGNED; vert_mark[b] = 1'b1; end
      if (!vert_mark[c]) begin vert_val[c] = UNASSIGNED; vert_mark[c] = 1'b1; end
      vert_val[a] = 2'((6 - (vert_val[b] + vert_val[c])) % 3);
      vert_mark[a] = 1'b1;
    end else if (!vert_mark[b]) begin
      if (!vert_mark[c]) begin vert_val[c] = UNASSIGNED; vert_mark[c] = 1'b1; end
      vert_val[b] = 2'((7 - (vert_val[a] + vert_val[c])) % 3);
      vert_mark[b] = 1'b1;
    end else begin
      vert_val[c] = 2'((8 - (vert_val[a] + vert_val[b])) % 3);
      vert_mark[c] = 1'b1;
    end
  endfunction

  // Cumulative assigned counts per rank block.
  function automatic void build_ranks();
    int lg, nb, cnt;
    lg = eff_lg();
    nb = (eff_count() + (1 << lg) - 1) >> lg;
    cnt = 0;
    for (int i = 0; i < nb && i < NBLK; i++) begin
      blk_count[i] = 13'(cnt);
      blk_built[i] = 1'b1;
      for (int v = i << lg; v < ((i + 1) << lg) && v < NV; v++)
        if (vert_val[v] != UNASSIGNED) cnt++;
    end
  endfunction

  function automatic int rank_below(int q);
    int lg, idx, r;
    lg = eff_lg();
    idx = q >> lg;
    r = blk_built[idx] ? blk_count[idx] : 0;
    for (int v = idx << lg; v < q; v++)
      if (vert_val[v] != UNASSIGNED) r++;
    return r;
  endfunction

  // Apply one accepted item to the shadow state; queries return their rank.
  function automatic int apply_item(op_t op, int a, int b, int c, int q);
    case (op)
      OP_CLEAR:  clear_values();
      OP_ASSIGN: assign_edge(a, b, c);
      OP_BUILD:  build_ranks();
      default:   return rank_below(q);
    endcase
    return -1;
  endfunction

  // Offer one item with random gaps; update the prediction when taken.
  task automatic send_item(op_t op, int a, int b, int c, int q, bit typed, int rank);
    int r;
    while ($urandom_range(99) < snd_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_vertex_a <= VERT_W'(a);
    in_vertex_b <= VERT_W'(b);
    in_vertex_c <= VERT_W'(c);
    in_query_vertex <= VERT_W'(q);
    do @(posedge clk); while (in_stall);
    r = apply_item(op, a, b, c, q);
    if (op == OP_QUERY) rank_queue.push_back(RANK_W'(typed ? rank : r));
  endtask

  // Let the block drain before touching configuration.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rank_queue.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_config(int count, int lg);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= CFG_VERTEX_COUNT;
    cfg_wdata <= 13'(count);
    @(negedge clk);
    cfg_index <= CFG_BLOCK_LOG2;
    cfg_wdata <= 13'(lg);
    @(negedge clk);
    cfg_we <= 1'b0;
    vcount_reg = 13'(count);
    lg_reg = 4'(lg);
  endtask

  function automatic void add_row(op_t op, int a, int b, int c, int q, bit typed, int rank);
    row_t rw;
    rw.op = op; rw.a = a; rw.b = b; rw.c = c; rw.q = q;
    rw.typed = typed; rw.rank = rank;
    rows.push_back(rw);
  endfunction

  // Random vertex: usually inside the configured count, sometimes anywhere.
  function automatic int pick_vertex();
    if ($urandom_range(9) < 2) return $urandom_range(NV - 1);
    return $urandom_range(eff_count() - 1);
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (rank_queue.size() == 0) begin
        $error("unexpected result: rank %0d", out_rank);
        errors++;
      end else begin
        if (out_rank !== rank_queue[0]) begin
          $error("rank mismatch: expected %0d, actual %0d", rank_queue[0], out_rank);
          errors++;
        end
        void'(rank_queue.pop_front());
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tb_bdz_assign_and_rank_core NOT OK");
      $finish;
    end
  end

  int seg_count [SEGMENTS] = '{4096, 8191, 1, 100, 4096, 300, 2000, 37};
  int seg_lg    [SEGMENTS] = '{7, 15, 0, 2, 12, 5, 13, 3};

  initial begin
    int a, b, c, q, sel, lg;
    op_t op;
    clear_values();
    for (int i = 0; i < NBLK; i++) begin
      blk_count[i] = '0;
      blk_built[i] = 1'b0;
    end
    vcount_reg = 13'd4096;
    lg_reg = 4'd7;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: reset state, repeated vertices, every assign branch, clear.
    add_row(OP_BUILD,  0, 0, 0, 0, 0, 0);
    add_row(OP_QUERY,  0, 0, 0, 0, 1, 0);
    add_row(OP_QUERY,  0, 0, 0, 4095, 1, 0);
    add_row(OP_ASSIGN, 0, 1, 2, 0, 0, 0);
    add_row(OP_ASSIGN, 4095, 4095, 4095, 0, 0, 0);
    add_row(OP_ASSIGN, 0, 1, 2, 0, 0, 0);
    add_row(OP_ASSIGN, 1, 3, 5, 0, 0, 0);
    add_row(OP_ASSIGN, 2, 3, 6, 0, 0, 0);
    add_row(OP_BUILD,  0, 0, 0, 0, 0, 0);
    add_row(OP_QUERY,  0, 0, 0, 4095, 1, 4);
    add_row(OP_QUERY,  0, 0, 0, 3, 1, 2);
    add_row(OP_QUERY,  0, 0, 0, 7, 1, 4);
    add_row(OP_ASSIGN, 4095, 0, 4095, 4095, 0, 0);
    add_row(OP_ASSIGN, 4094, 4093, 4094, 0, 0, 0);
    add_row(OP_ASSIGN, 2730, 1365, 4095, 2730, 0, 0);
    add_row(OP_BUILD,  0, 0, 0, 0, 0, 0);
    add_row(OP_QUERY,  0, 0, 0, 4094, 0, 0);
    add_row(OP_QUERY,  0, 0, 0, 2048, 0, 0);
    add_row(OP_CLEAR,  0, 0, 0, 0, 0, 0);
    add_row(OP_BUILD,  0, 0, 0, 0, 0, 0);
    add_row(OP_QUERY,  0, 0, 0, 4095, 1, 0);
    foreach (rows[i])
      send_item(rows[i].op, rows[i].a, rows[i].b, rows[i].c, rows[i].q,
                rows[i].typed, rows[i].rank);

    // Random part: one configuration per segment, idling pattern by phase.
    for (int s = 0; s < SEGMENTS; s++) begin
      write_config(seg_count[s], seg_lg[s]);
      if (s < 3) begin
        snd_idle_pct = 31; rcv_idle_pct = 55;
      end else if (s < 6) begin
        snd_idle_pct = 55; rcv_idle_pct = 31;
      end else begin
        snd_idle_pct = 0; rcv_idle_pct = 0;
      end
      // Fresh rank table for the new block size.
      send_item(OP_BUILD, 0, 0, 0, 0, 0, 0);
      if (s == 3) hold_req++;
      for (int n = 0; n < RAND_ITEMS / SEGMENTS; n++) begin
        sel = $urandom_range(99);
        a = pick_vertex();
        b = pick_vertex();
        c = pick_vertex();
        q = $urandom_range(NV - 1);
        if (sel < 2) op = OP_CLEAR;
        else if (sel < 9) op = OP_BUILD;
        else if (sel < 45) op = OP_QUERY;
        else op = OP_ASSIGN;
        // Repeated vertices now and then.
        if ($urandom_range(19) == 0) b = a;
        if ($urandom_range(19) == 0) c = b;
        if (s == 3 && n < 20) op = OP_QUERY;
        if (op == OP_QUERY) begin
          lg = eff_lg();
          if ($urandom_range(1) == 0) q = pick_vertex();
          if (!blk_built[q >> lg]) q = $urandom_range((1 << lg) - 1);
          if (!blk_built[q >> lg]) op = OP_BUILD;
        end
        send_item(op, a, b, c, q, 0, 0);
      end
    end

    wait_drained();
    if (errors == 0 && rank_queue.size() == 0) begin
      $display("tb_bdz_assign_and_rank_core OK");
    end else begin
      $display("tb_bdz_assign_and_rank_core NOT OK");
    end
    $finish;
  end

endmodule
